[sv/jc3d_pkg.sv]
// Shared types and constants for the 3D Jacobi stencil block.
`timescale 1ns / 1ps
package jc3d_pkg;

    localparam int MAX_X_DEF = 64;
    localparam int MAX_Y_DEF = 64;
    localparam int MAX_Z_DEF = 1024;

    localparam int DIMXY_W = 7;
    localparam int DIMZ_W  = 11;
    localparam int WORD_W  = 32;
    localparam int RSUM_W  = 64;
    localparam int CIDX_W  = 3;

    localparam logic [CIDX_W-1:0] CFG_DIM_X  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_DIM_Y  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_DIM_Z  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_COEF_X = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_COEF_Y = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_COEF_Z = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_SCALE  = 3'd6;

    // which neighbor a plane read fetches
    typedef enum logic [2:0] {
        RT_C, RT_XA, RT_XB, RT_YA, RT_YB, RT_Z
    } t_rtag;

    // multiplier operations, in issue order
    typedef enum logic [3:0] {
        OP_SXC, OP_SYC, OP_SZC, OP_LX, OP_LY, OP_LZ, OP_MLO, OP_MHI, OP_SQ
    } t_mop;

    typedef struct packed {
        logic  capture;
        logic  rd_en;
        t_rtag rd_tag;
        logic  mul_en;
        t_mop  mul_op;
        logic  rnd_en;
        logic  out_load;
        logic  wr_en;
        logic  clr_acc;
    } t_cmd;

endpackage

[sv/jc3d_ctrl.sv]
// Sequencer: grid position, item state machine and datapath commands.
`timescale 1ns / 1ps
module jc3d_ctrl #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(MAX_X+1)-1:0]          i_dx,
    input  logic [$clog2(MAX_Y+1)-1:0]          i_dy,
    input  logic [$clog2(MAX_Z+1)-1:0]          i_dz,
    input  logic                                i_restart,
    input  logic                                i_s_valid,
    output logic                                o_s_ready,
    input  logic                                i_out_free,
    output jc3d_pkg::t_cmd                      o_cmd,
    output logic [$clog2(MAX_X*MAX_Y)-1:0]      o_idx,
    output logic                                o_cur_plane,
    output logic                                o_last
);
    import jc3d_pkg::*;

    localparam int XW  = $clog2(MAX_X);
    localparam int YW  = $clog2(MAX_Y);
    localparam int ZW  = $clog2(MAX_Z);
    localparam int XDW = $clog2(MAX_X+1);
    localparam int YDW = $clog2(MAX_Y+1);
    localparam int ZDW = $clog2(MAX_Z+1);
    localparam int IW  = $clog2(MAX_X*MAX_Y);
    localparam logic [3:0] RD_LAST  = 4'd5;
    localparam logic [3:0] MUL_LAST = 4'd10;
    localparam logic [3:0] ST_RND   = 4'd8;
    localparam logic [3:0] ST_SQ    = 4'd9;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_OUT, S_WR} t_state;

    t_state          r_state;
    logic [3:0]      r_step;
    logic [XW-1:0]   r_x;
    logic [YW-1:0]   r_y;
    logic [ZW-1:0]   r_z;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_row;
    logic            r_last;

    logic [XDW-1:0]  x_e;
    logic [YDW-1:0]  y_e;
    logic [ZDW-1:0]  z_e;
    logic            accept;
    logic            interior;
    logic            x_end;
    logic            y_end;
    logic            z_end;
    logic            last_pt;

    assign x_e = XDW'(r_x);
    assign y_e = YDW'(r_y);
    assign z_e = ZDW'(r_z);

    assign accept   = i_s_valid && (r_state == S_IDLE);
    assign interior = (z_e >= ZDW'(2)) && (x_e >= XDW'(1)) && (x_e <= i_dx - XDW'(2))
                      && (y_e >= YDW'(1)) && (y_e <= i_dy - YDW'(2));
    assign last_pt  = (x_e == i_dx - XDW'(2)) && (y_e == i_dy - YDW'(2))
                      && (z_e == i_dz - ZDW'(1));
    assign x_end    = (x_e == i_dx - XDW'(1));
    assign y_end    = (y_e == i_dy - YDW'(1));
    assign z_end    = (z_e == i_dz - ZDW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_idx   <= '0;
            r_row   <= '0;
            r_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_last  <= last_pt;
                        r_step  <= '0;
                        r_state <= interior ? S_RD : S_WR;
                    end
                end
                S_RD: begin
                    if (r_step == RD_LAST) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_MUL: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == MUL_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_free) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // position: restart wins over the raster advance
            if (i_restart) begin
                r_x   <= '0;
                r_y   <= '0;
                r_z   <= '0;
                r_idx <= '0;
                r_row <= '0;
            end else if (r_state == S_WR) begin
                if (x_end) begin
                    r_x <= '0;
                    if (y_end) begin
                        r_y   <= '0;
                        r_row <= '0;
                        r_idx <= '0;
                        r_z   <= z_end ? '0 : r_z + ZW'(1);
                    end else begin
                        r_y   <= r_y + YW'(1);
                        r_row <= r_row + IW'(MAX_X);
                        r_idx <= r_row + IW'(MAX_X);
                    end
                end else begin
                    r_x   <= r_x + XW'(1);
                    r_idx <= r_idx + IW'(1);
                end
            end
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = accept;
        o_cmd.clr_acc = i_restart;
        unique case (r_state)
            S_IDLE: ;
            S_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_tag = t_rtag'(r_step[2:0]);
            end
            S_MUL: begin
                if (r_step <= 4'd7) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.mul_op = t_mop'(r_step);
                end else if (r_step == ST_RND) begin
                    o_cmd.rnd_en = 1'b1;
                end else if (r_step == ST_SQ) begin
                    o_cmd.mul_en = 1'b1;
                    o_cmd.mul_op = OP_SQ;
                end
            end
            S_OUT: o_cmd.out_load = i_out_free;
            S_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.clr_acc = i_restart || (x_end && y_end && z_end);
            end
            default: ;
        endcase
    end

    assign o_s_ready   = (r_state == S_IDLE);
    assign o_idx       = r_idx;
    assign o_cur_plane = r_z[0];
    assign o_last      = r_last;

    a_interior_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && interior) |=> (r_state == S_RD))
        else $error("interior point did not start neighbor reads");
    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_restart |=> (r_x == '0 && r_y == '0 && r_z == '0 && r_idx == '0))
        else $error("restart did not return to grid origin");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (x_e < i_dx) && (y_e < i_dy) && (z_e < i_dz))
        else $error("grid position outside dimensions");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_free) |=> (r_state == S_OUT))
        else $error("result left before output register was free");

endmodule

[sv/jc3d_dp.sv]
// Datapath: plane and source memories, shared multiplier, accumulators.
`timescale 1ns / 1ps
module jc3d_dp #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  jc3d_pkg::t_cmd                          i_cmd,
    input  logic [$clog2(MAX_X*MAX_Y)-1:0]          i_idx,
    input  logic                                    i_cur_plane,
    input  logic signed [jc3d_pkg::WORD_W-1:0]      i_u,
    input  logic signed [jc3d_pkg::WORD_W-1:0]      i_f,
    input  logic [jc3d_pkg::WORD_W-1:0]             i_coef_x,
    input  logic [jc3d_pkg::WORD_W-1:0]             i_coef_y,
    input  logic [jc3d_pkg::WORD_W-1:0]             i_coef_z,
    input  logic [jc3d_pkg::WORD_W-1:0]             i_scale,
    output logic signed [jc3d_pkg::WORD_W-1:0]      o_new_u,
    output logic [jc3d_pkg::RSUM_W-1:0]             o_rsum
);
    import jc3d_pkg::*;

    localparam int PW = MAX_X * MAX_Y;
    localparam int PD = 2 * PW;
    localparam int AW = $clog2(PD);

    logic [WORD_W-1:0] plane_mem [PD];
    logic [WORD_W-1:0] src_mem   [PW];

    logic signed [WORD_W-1:0] r_u;
    logic signed [WORD_W-1:0] r_f;
    logic [WORD_W-1:0]        r_pq;
    logic [WORD_W-1:0]        r_sq;
    logic                     r_rv;
    t_rtag                    r_rt;
    logic signed [31:0]       r_c;
    logic signed [31:0]       r_fs;
    logic signed [32:0]       r_sx;
    logic signed [32:0]       r_sy;
    logic signed [32:0]       r_sz;
    logic signed [69:0]       r_inner;
    logic signed [69:0]       r_lap;
    logic signed [68:0]       r_prod;
    logic                     r_pv;
    t_mop                     r_pt;
    logic [99:0]              r_ps;
    logic [31:0]              r_rmag;
    logic                     r_rbig;
    logic [RSUM_W-1:0]        r_acc;

    logic [AW-1:0]       a_idx;
    logic [AW-1:0]       b_prev;
    logic [AW-1:0]       b_cur;
    logic [AW-1:0]       rd_addr;
    logic signed [34:0]  lx;
    logic signed [34:0]  ly;
    logic signed [34:0]  lz;
    logic [69:0]         inner_mag;
    logic signed [35:0]  op_a;
    logic [31:0]         op_b;
    logic signed [69:0]  rv;
    logic [69:0]         rm;
    logic [RSUM_W-1:0]   sq;
    logic [RSUM_W:0]     acc_sum;
    logic [100:0]        nu_sum;
    logic [52:0]         nu_m;

    assign a_idx  = AW'(i_idx);
    assign b_prev = i_cur_plane ? '0 : AW'(PW);
    assign b_cur  = i_cur_plane ? AW'(PW) : '0;

    always_comb begin
        unique case (i_cmd.rd_tag)
            RT_C:    rd_addr = b_prev + a_idx;
            RT_XA:   rd_addr = b_prev + a_idx + AW'(1);
            RT_XB:   rd_addr = b_prev + a_idx - AW'(1);
            RT_YA:   rd_addr = b_prev + a_idx + AW'(MAX_X);
            RT_YB:   rd_addr = b_prev + a_idx - AW'(MAX_X);
            RT_Z:    rd_addr = b_cur + a_idx;
            default: rd_addr = b_cur + a_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            plane_mem[b_cur + a_idx] <= r_u;
        end
        if (i_cmd.rd_en) begin
            r_pq <= plane_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            src_mem[i_idx] <= r_f;
        end
        if (i_cmd.rd_en) begin
            r_sq <= src_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_u <= i_u;
            r_f <= i_f;
        end
    end

    // neighbor gather from the registered plane read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else begin
            r_rv <= i_cmd.rd_en;
        end
        r_rt <= i_cmd.rd_tag;
        if (r_rv) begin
            unique case (r_rt)
                RT_C: begin
                    r_c  <= $signed(r_pq);
                    r_fs <= $signed(r_sq);
                end
                RT_XA:   r_sx <= 33'($signed(r_pq));
                RT_XB:   r_sx <= r_sx + 33'($signed(r_pq));
                RT_YA:   r_sy <= 33'($signed(r_pq));
                RT_YB:   r_sy <= r_sy + 33'($signed(r_pq));
                RT_Z:    r_sz <= 33'($signed(r_pq)) + 33'(r_u);
                default: ;
            endcase
        end
    end

    assign lx = 35'(r_sx) - (35'(r_c) <<< 1);
    assign ly = 35'(r_sy) - (35'(r_c) <<< 1);
    assign lz = 35'(r_sz) - (35'(r_c) <<< 1);
    assign inner_mag = r_inner[69] ? 70'(-r_inner) : 70'(r_inner);

    always_comb begin
        unique case (i_cmd.mul_op)
            OP_SXC:  begin op_a = 36'(r_sx); op_b = i_coef_x; end
            OP_SYC:  begin op_a = 36'(r_sy); op_b = i_coef_y; end
            OP_SZC:  begin op_a = 36'(r_sz); op_b = i_coef_z; end
            OP_LX:   begin op_a = 36'(lx);   op_b = i_coef_x; end
            OP_LY:   begin op_a = 36'(ly);   op_b = i_coef_y; end
            OP_LZ:   begin op_a = 36'(lz);   op_b = i_coef_z; end
            OP_MLO:  begin op_a = $signed({4'b0, inner_mag[31:0]}); op_b = i_scale; end
            OP_MHI:  begin op_a = $signed({1'b0, inner_mag[66:32]}); op_b = i_scale; end
            OP_SQ:   begin op_a = $signed({4'b0, r_rmag}); op_b = r_rmag; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // residual before squaring, rounded half away from zero to Q16.16
    assign rv = (70'(r_fs) <<< 16) - r_lap;
    assign rm = (rv[69] ? 70'(-rv) : 70'(rv)) + 70'(32768);

    assign sq      = r_rbig ? '1 : r_prod[63:0];
    assign acc_sum = {1'b0, r_acc} + {1'b0, sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_cmd.mul_en;
            if (i_cmd.clr_acc) begin
                r_acc <= '0;
            end else if (r_pv && r_pt == OP_SQ) begin
                r_acc <= acc_sum[RSUM_W] ? '1 : acc_sum[RSUM_W-1:0];
            end
        end
        r_pt <= i_cmd.mul_op;
        if (i_cmd.mul_en) begin
            r_prod <= op_a * $signed({1'b0, op_b});
        end
        if (i_cmd.rnd_en) begin
            r_rbig <= |rm[69:48];
            r_rmag <= rm[47:16];
        end
        // center beat seeds the inner sum with -f and clears the Laplacian sum; products land later
        if (r_rv && r_rt == RT_C) begin
            r_inner <= -(70'($signed(r_sq)) <<< 16);
            r_lap   <= '0;
        end else if (r_pv) begin
            unique case (r_pt)
                OP_SXC, OP_SYC, OP_SZC: r_inner <= r_inner + 70'(r_prod);
                OP_LX, OP_LY, OP_LZ:    r_lap   <= r_lap + 70'(r_prod);
                OP_MLO:  r_ps <= 100'(r_prod[63:0]);
                OP_MHI:  r_ps <= r_ps + 100'({r_prod[66:0], 32'b0});
                OP_SQ:   ;
                default: ;
            endcase
        end
    end

    // Jacobi update: round product >> 48, then saturate to 32 bits
    assign nu_sum = {1'b0, r_ps} + 101'(48'h8000_0000_0000);
    assign nu_m   = nu_sum[100:48];

    always_comb begin
        if (r_inner[69]) begin
            if (nu_m > 53'h8000_0000) begin
                o_new_u = 32'sh8000_0000;
            end else begin
                o_new_u = $signed(32'd0 - nu_m[31:0]);
            end
        end else begin
            if (nu_m > 53'h7FFF_FFFF) begin
                o_new_u = 32'sh7FFF_FFFF;
            end else begin
                o_new_u = $signed(nu_m[31:0]);
            end
        end
    end

    assign o_rsum = r_acc;

endmodule

[sv/jacobi_3d_poisson_stencil_top.sv]
// Top level: 3D 7-point Jacobi stencil with squared-residual accumulation.
// One point at a time: the next input beat is accepted only after the last is written;
//   interior points are bounded by the single read port of the plane memory
//   (6 reads) and one shared multiplier (9 ops), and wait while the output is full.
// Reset (sync, active low): position, residual sum and output clear; config returns
//   to dims 3, coefs 1.0, scale 0. Plane memories are not cleared.
`timescale 1ns / 1ps
module jacobi_3d_poisson_stencil_top #(
    parameter int MAX_X = jc3d_pkg::MAX_X_DEF,
    parameter int MAX_Y = jc3d_pkg::MAX_Y_DEF,
    parameter int MAX_Z = jc3d_pkg::MAX_Z_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream: [31:0] u_value, [63:32] f_value
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [63:0]                         s_axis_tdata,
    // result stream: [31:0] new_u, [95:32] residual_sum
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [95:0]                         m_axis_tdata,
    output logic                                m_axis_tlast,
    // register writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [jc3d_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [jc3d_pkg::WORD_W-1:0]         i_cfg_data
);
    import jc3d_pkg::*;

    localparam int XDW = $clog2(MAX_X+1);
    localparam int YDW = $clog2(MAX_Y+1);
    localparam int ZDW = $clog2(MAX_Z+1);
    localparam int IW  = $clog2(MAX_X*MAX_Y);

    logic [DIMXY_W-1:0] r_dim_x;
    logic [DIMXY_W-1:0] r_dim_y;
    logic [DIMZ_W-1:0]  r_dim_z;
    logic [WORD_W-1:0]  r_coef_x;
    logic [WORD_W-1:0]  r_coef_y;
    logic [WORD_W-1:0]  r_coef_z;
    logic [WORD_W-1:0]  r_scale;

    logic               r_out_v;
    logic [WORD_W-1:0]  r_out_u;
    logic [RSUM_W-1:0]  r_out_sum;
    logic               r_out_last;

    logic [XDW-1:0]     dx;
    logic [YDW-1:0]     dy;
    logic [ZDW-1:0]     dz;
    logic               cfg_wr;
    logic               restart;
    logic               out_free;
    t_cmd               cmd;
    logic [IW-1:0]      idx;
    logic               cur_plane;
    logic               last;
    logic signed [WORD_W-1:0] new_u;
    logic [RSUM_W-1:0]  rsum;

    // config port never stalls; write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    // any dimension write starts a new grid
    assign restart     = cfg_wr && (i_cfg_index == CFG_DIM_X || i_cfg_index == CFG_DIM_Y
                                    || i_cfg_index == CFG_DIM_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_x  <= DIMXY_W'(3);
            r_dim_y  <= DIMXY_W'(3);
            r_dim_z  <= DIMZ_W'(3);
            r_coef_x <= 32'h0001_0000;
            r_coef_y <= 32'h0001_0000;
            r_coef_z <= 32'h0001_0000;
            r_scale  <= '0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_DIM_X:  r_dim_x  <= i_cfg_data[DIMXY_W-1:0];
                CFG_DIM_Y:  r_dim_y  <= i_cfg_data[DIMXY_W-1:0];
                CFG_DIM_Z:  r_dim_z  <= i_cfg_data[DIMZ_W-1:0];
                CFG_COEF_X: r_coef_x <= i_cfg_data;
                CFG_COEF_Y: r_coef_y <= i_cfg_data;
                CFG_COEF_Z: r_coef_z <= i_cfg_data;
                CFG_SCALE:  r_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // dimensions as used: clamped to [3, MAX]
    always_comb begin
        if (32'(r_dim_x) < 32'd3)            dx = XDW'(3);
        else if (32'(r_dim_x) > 32'(MAX_X))  dx = XDW'(MAX_X);
        else                                 dx = XDW'(r_dim_x);
        if (32'(r_dim_y) < 32'd3)            dy = YDW'(3);
        else if (32'(r_dim_y) > 32'(MAX_Y))  dy = YDW'(MAX_Y);
        else                                 dy = YDW'(r_dim_y);
        if (32'(r_dim_z) < 32'd3)            dz = ZDW'(3);
        else if (32'(r_dim_z) > 32'(MAX_Z))  dz = ZDW'(MAX_Z);
        else                                 dz = ZDW'(r_dim_z);
    end

    jc3d_ctrl #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dx        (dx),
        .i_dy        (dy),
        .i_dz        (dz),
        .i_restart   (restart),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_out_free  (out_free),
        .o_cmd       (cmd),
        .o_idx       (idx),
        .o_cur_plane (cur_plane),
        .o_last      (last)
    );

    jc3d_dp #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_cur_plane (cur_plane),
        .i_u         ($signed(s_axis_tdata[31:0])),
        .i_f         ($signed(s_axis_tdata[63:32])),
        .i_coef_x    (r_coef_x),
        .i_coef_y    (r_coef_y),
        .i_coef_z    (r_coef_z),
        .i_scale     (r_scale),
        .o_new_u     (new_u),
        .o_rsum      (rsum)
    );

    // output register: holds one result beat so the next point can start
    assign out_free = !r_out_v || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_v <= 1'b0;
        end
        if (cmd.out_load) begin
            r_out_u    <= new_u;
            r_out_sum  <= rsum;
            r_out_last <= last;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_sum, r_out_u};
    assign m_axis_tlast  = r_out_last;

endmodule
